/* rtl/core/env_sensor_compensation_assert.svh */
// Assertion macros for the sensor compensation block.
// Included by the top level; no other dependencies.
`ifndef ENV_SENSOR_COMPENSATION_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ESC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ESC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ESC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/esc_pkg.sv */
// Types, constants and multiply helpers of the sensor compensation block.
// No dependencies.
package esc_pkg;

	localparam int DIV_W     = 64;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TEMP_CAL  = 3'd0,
		REG_PRES_LOW  = 3'd1,
		REG_PRES_HIGH = 3'd2,
		REG_PRES_LAST = 3'd3,
		REG_HUM_CAL   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [19:0] raw_pressure;
		logic [19:0] raw_temperature;
		logic [15:0] raw_humidity;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] temperature_centideg;
		logic [31:0]        pressure_q24_8;
		logic [16:0]        humidity_q22_10;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [63:0]          value;
	} cfg_t;

	// results that ride along the divider
	typedef struct packed {
		logic signed [31:0] temp;
		logic [16:0]        hum;
		logic               neg;
		logic               zero;
	} side_t;

	localparam logic [32:0] T_FINE_OFS  = 33'd128000;
	localparam logic [63:0] PRES_BASE   = 64'd1048576;
	localparam logic [15:0] PRES_SCALE  = 16'd3125;
	localparam logic [31:0] HUM_OFS     = 32'd76800;
	localparam logic [31:0] HUM_RND     = 32'd16384;
	localparam logic [31:0] HUM_Y_OFS   = 32'd2097152;
	localparam logic [31:0] HUM_Y_MUL   = 32'd32768;
	localparam logic [31:0] HUM_Y_RND   = 32'd8192;
	localparam logic [31:0] HUM_MAX     = 32'd419430400;

	// low 32 bits of a product
	function automatic logic [31:0] mul_lo32(logic [31:0] a, logic [31:0] b);
		return a * b;
	endfunction

	// unsigned 32-bit low half times signed 16-bit, sign-extended to 64
	function automatic logic [63:0] mul_s_lo(logic [31:0] a, logic signed [15:0] b);
		logic signed [48:0] p;
		p = $signed({1'b0, a}) * b;
		return {{15{p[48]}}, p};
	endfunction

endpackage

/* rtl/core/esc_chan_if.sv */
// Valid/ready channel carrying one payload beat.
// Payload types come from esc_pkg.
interface esc_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/esc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// Uses esc_pkg for width and sideband type.
module esc_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [esc_pkg::DIV_W-1:0] dvd,
	input  logic [esc_pkg::DIV_W-1:0] dvs,
	input  esc_pkg::side_t           in_side,
	output logic                     out_valid,
	output logic [esc_pkg::DIV_W-1:0] quo,
	output esc_pkg::side_t           out_side
);
	localparam int W = esc_pkg::DIV_W;

	logic [W-1:0]   vld_s;
	logic [W-1:0]   rem_s  [W];
	logic [W-1:0]   quo_s  [W];
	logic [W-1:0]   dvs_s  [W];
	esc_pkg::side_t side_s [W];

	logic [W-1:0]   rem_n  [W];
	logic [W-1:0]   quo_n  [W];
	logic [W-1:0]   src_rem [W];
	logic [W-1:0]   src_quo [W];
	logic [W-1:0]   src_dvs [W];

	always_comb begin
		logic [W:0] trial;
		src_rem[0] = '0;
		src_quo[0] = dvd;
		src_dvs[0] = dvs;
		for (int k = 1; k < W; k++) begin
			src_rem[k] = rem_s[k-1];
			src_quo[k] = quo_s[k-1];
			src_dvs[k] = dvs_s[k-1];
		end
		for (int k = 0; k < W; k++) begin
			trial = {src_rem[k], src_quo[k][W-1]} - {1'b0, src_dvs[k]};
			if (!trial[W]) begin
				rem_n[k] = trial[W-1:0];
				quo_n[k] = {src_quo[k][W-2:0], 1'b1};
			end else begin
				rem_n[k] = {src_rem[k][W-2:0], src_quo[k][W-1]};
				quo_n[k] = {src_quo[k][W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[W-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			for (int k = 0; k < W; k++) begin
				rem_s[k] <= rem_n[k];
				quo_s[k] <= quo_n[k];
				dvs_s[k] <= src_dvs[k];
			end
			for (int k = 1; k < W; k++)
				side_s[k] <= side_s[k-1];
		end
	end

	assign out_valid = vld_s[W-1];
	assign quo       = quo_s[W-1];
	assign out_side  = side_s[W-1];
endmodule

/* rtl/core/env_sensor_compensation.sv */
// Sensor compensation: temperature, pressure and humidity from one raw sample.
// Accepts one sample per cycle while no result beat is stalled at the output.
// The pressure path runs through the 64-stage divider.
// The whole pipeline halts while a result beat waits at the output register.
// Reset clears valid bits and calibration registers; no clearing pass.
`include "env_sensor_compensation_assert.svh"
module env_sensor_compensation (
	input  logic       clk,
	input  logic       arst_n,
	esc_chan_if.sink   cfg,
	esc_chan_if.sink   sample,
	esc_chan_if.source result
);
	logic [47:0] cal_t_q;
	logic [63:0] cal_pl_q, cal_ph_q, cal_h_q;
	logic [15:0] cal_p9_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_t_q  <= '0;
			cal_pl_q <= '0;
			cal_ph_q <= '0;
			cal_p9_q <= '0;
			cal_h_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				esc_pkg::REG_TEMP_CAL:  cal_t_q  <= cfg.data.value[47:0];
				esc_pkg::REG_PRES_LOW:  cal_pl_q <= cfg.data.value;
				esc_pkg::REG_PRES_HIGH: cal_ph_q <= cfg.data.value;
				esc_pkg::REG_PRES_LAST: cal_p9_q <= cfg.data.value[15:0];
				esc_pkg::REG_HUM_CAL:   cal_h_q  <= cfg.data.value;
				default: ;
			endcase
		end
	end
	assign cfg.ready = 1'b1;

	// coefficients
	logic [15:0] t1, p1;
	logic [31:0] t2x, t3x, h2x, h5x, h6x;
	logic [7:0]  h1, h3;
	logic [11:0] h4;
	logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1  = cal_t_q[15:0];
	assign t2x = {{16{cal_t_q[31]}}, cal_t_q[31:16]};
	assign t3x = {{16{cal_t_q[47]}}, cal_t_q[47:32]};
	assign p1  = cal_pl_q[15:0];
	assign p2  = cal_pl_q[31:16];
	assign p3  = cal_pl_q[47:32];
	assign p4  = cal_pl_q[63:48];
	assign p5  = cal_ph_q[15:0];
	assign p6  = cal_ph_q[31:16];
	assign p7  = cal_ph_q[47:32];
	assign p8  = cal_ph_q[63:48];
	assign p9  = cal_p9_q;
	assign h1  = cal_h_q[7:0];
	assign h2x = {{16{cal_h_q[23]}}, cal_h_q[23:8]};
	assign h3  = cal_h_q[31:24];
	assign h4  = cal_h_q[43:32];
	assign h5x = {{20{cal_h_q[55]}}, cal_h_q[55:44]};
	assign h6x = {{24{cal_h_q[63]}}, cal_h_q[63:56]};

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, v_s14, v_s15, v_s16;
	logic dv_valid;

	assign adv          = !v_s16 || result.ready;
	assign sample.ready = adv;

	// stage registers
	logic [31:0] a_s1, dd_s1, v1_s2, m_s2, tf_s3;
	logic [19:0] rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6;
	logic [15:0] rh_s1, rh_s2, rh_s3;
	logic [31:0] temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9;
	logic [63:0] w1sq_s4, w1p5_s4, w1p2_s4;
	logic [63:0] m6lo_s5, m3lo_s5, w1p5_s5, w1p2_s5;
	logic [31:0] m6hi_s5, m3hi_s5;
	logic [63:0] w2_s6, w1b_s6;
	logic [63:0] m1lo_s7, npre_s7;
	logic [31:0] m1hi_s7;
	logic [63:0] w1c_s8, nlo_s8;
	logic [31:0] nhi_s8;
	logic [63:0] num_s9, den_s9;
	logic [63:0] ma_s10, mb_s10;
	esc_pkg::side_t side_s10;
	logic [31:0] xb_s4, h5v_s4, vh6_s4, vh3_s4, x_s5, y_s5, x_s6, y3_s6;
	logic [31:0] vv_s7, vv_s8, ss_s8, vv_s9, t9_s9;

	logic [63:0] dv_quo;
	esc_pkg::side_t dv_side;
	esc_pkg::side_t side_s11, side_s12, side_s13, side_s14, side_s15;
	logic [63:0] p_s11, p_s12, ll_s12, m8lo_s12, p_s13, qq_s13, w2b_s13;
	logic [31:0] lh_s12, m8hi_s12, m9hi_s14;
	logic [63:0] p_s14, w2b_s14, m9lo_s14, sum_s15;
	esc_pkg::result_t res_s16;

	// combinational terms
	logic [31:0] a_pre, d_pre, t5, hv, x7h, q13l, q13h;
	logic signed [32:0] w1;
	logic signed [65:0] w1sq;
	logic signed [48:0] w1p5, w1p2;
	logic [63:0] x7, pd, h_m9, h_m8, h_m3, h_m1;
	logic [31:0] hv10, hum_c;
	logic [63:0] pres_w;

	always_comb begin
		a_pre = {15'd0, sample.data.raw_temperature[19:3]} - {15'd0, t1, 1'b0};
		d_pre = {16'd0, sample.data.raw_temperature[19:4]} - {16'd0, t1};
		t5    = tf_s3 * 32'd5 + 32'd128;
		w1    = $signed({tf_s3[31], tf_s3}) - $signed(esc_pkg::T_FINE_OFS);
		w1sq  = w1 * w1;
		w1p5  = w1 * p5;
		w1p2  = w1 * p2;
		hv    = tf_s3 - esc_pkg::HUM_OFS;
		h_m3  = m3lo_s5 + {m3hi_s5, 32'd0};
		x7    = w1b_s6 + (64'd1 << 47);
		x7h   = x7[63:32];
		pd    = esc_pkg::PRES_BASE - {44'd0, rp_s6};
		h_m1  = m1lo_s7 + {m1hi_s7, 32'd0};
		hv10  = vv_s9 - 32'($signed(t9_s9) >>> 4);
		if (hv10[31])
			hum_c = '0;
		else if (hv10 > esc_pkg::HUM_MAX)
			hum_c = esc_pkg::HUM_MAX;
		else
			hum_c = hv10;
		q13l  = p_s11[44:13];
		q13h  = 32'($signed(p_s11[63:32]) >>> 13);
		h_m8  = m8lo_s12 + {m8hi_s12, 32'd0};
		h_m9  = m9lo_s14 + {m9hi_s14, 32'd0};
		pres_w = 64'($signed(sum_s15) >>> 8) + {{44{p7[15]}}, p7, 4'd0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10} <= '0;
			{v_s11, v_s12, v_s13, v_s14, v_s15, v_s16} <= '0;
		end else if (adv) begin
			v_s1  <= sample.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= dv_valid;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// temperature
			a_s1  <= esc_pkg::mul_lo32(a_pre, t2x);
			dd_s1 <= esc_pkg::mul_lo32(d_pre, d_pre);
			rp_s1 <= sample.data.raw_pressure;
			rh_s1 <= sample.data.raw_humidity;
			v1_s2 <= 32'($signed(a_s1) >>> 11);
			m_s2  <= esc_pkg::mul_lo32(32'($signed(dd_s1) >>> 12), t3x);
			rp_s2 <= rp_s1;
			rh_s2 <= rh_s1;
			tf_s3 <= v1_s2 + 32'($signed(m_s2) >>> 14);
			rp_s3 <= rp_s2;
			rh_s3 <= rh_s2;

			// s4: temperature result, pressure and humidity products
			temp_s4 <= 32'($signed(t5) >>> 8);
			w1sq_s4 <= w1sq[63:0];
			w1p5_s4 <= {{15{w1p5[48]}}, w1p5};
			w1p2_s4 <= {{15{w1p2[48]}}, w1p2};
			rp_s4   <= rp_s3;
			xb_s4   <= {2'd0, rh_s3, 14'd0} - {h4, 20'd0} + esc_pkg::HUM_RND;
			h5v_s4  <= esc_pkg::mul_lo32(hv, h5x);
			vh6_s4  <= esc_pkg::mul_lo32(hv, h6x);
			vh3_s4  <= esc_pkg::mul_lo32(hv, {24'd0, h3});

			// s5
			m6lo_s5 <= esc_pkg::mul_s_lo(w1sq_s4[31:0], p6);
			m6hi_s5 <= esc_pkg::mul_lo32(w1sq_s4[63:32], {{16{p6[15]}}, p6});
			m3lo_s5 <= esc_pkg::mul_s_lo(w1sq_s4[31:0], p3);
			m3hi_s5 <= esc_pkg::mul_lo32(w1sq_s4[63:32], {{16{p3[15]}}, p3});
			w1p5_s5 <= w1p5_s4;
			w1p2_s5 <= w1p2_s4;
			rp_s5   <= rp_s4;
			temp_s5 <= temp_s4;
			x_s5    <= 32'($signed(xb_s4 - h5v_s4) >>> 15);
			y_s5    <= esc_pkg::mul_lo32(32'($signed(vh6_s4) >>> 10),
				32'($signed(vh3_s4) >>> 11) + esc_pkg::HUM_Y_MUL);

			// s6
			w2_s6   <= m6lo_s5 + {m6hi_s5, 32'd0} + {w1p5_s5[46:0], 17'd0}
				+ {{13{p4[15]}}, p4, 35'd0};
			w1b_s6  <= 64'($signed(h_m3) >>> 8) + {w1p2_s5[51:0], 12'd0};
			rp_s6   <= rp_s5;
			temp_s6 <= temp_s5;
			x_s6    <= x_s5;
			y3_s6   <= esc_pkg::mul_lo32(32'($signed(y_s5) >>> 10) + esc_pkg::HUM_Y_OFS, h2x)
				+ esc_pkg::HUM_Y_RND;

			// s7
			m1lo_s7 <= {16'd0, 48'(x7[31:0]) * 48'(p1)};
			m1hi_s7 <= esc_pkg::mul_lo32(x7h, {16'd0, p1});
			npre_s7 <= {pd[32:0], 31'd0} - w2_s6;
			temp_s7 <= temp_s6;
			vv_s7   <= esc_pkg::mul_lo32(x_s6, 32'($signed(y3_s6) >>> 14));

			// s8
			w1c_s8  <= 64'($signed(h_m1) >>> 33);
			nlo_s8  <= {20'd0, 44'(npre_s7[31:0]) * 44'(esc_pkg::PRES_SCALE)};
			nhi_s8  <= esc_pkg::mul_lo32(npre_s7[63:32], {16'd0, esc_pkg::PRES_SCALE});
			temp_s8 <= temp_s7;
			vv_s8   <= vv_s7;
			ss_s8   <= esc_pkg::mul_lo32(32'($signed(vv_s7) >>> 15),
				32'($signed(vv_s7) >>> 15));

			// s9
			num_s9  <= nlo_s8 + {nhi_s8, 32'd0};
			den_s9  <= w1c_s8;
			temp_s9 <= temp_s8;
			vv_s9   <= vv_s8;
			t9_s9   <= esc_pkg::mul_lo32(32'($signed(ss_s8) >>> 7), {24'd0, h1});

			// s10: divider operands as magnitudes
			ma_s10        <= num_s9[63] ? 64'd0 - num_s9 : num_s9;
			mb_s10        <= den_s9[63] ? 64'd0 - den_s9 : den_s9;
			side_s10.temp <= temp_s9;
			side_s10.hum  <= hum_c[28:12];
			side_s10.neg  <= num_s9[63] ^ den_s9[63];
			side_s10.zero <= (den_s9 == 64'd0);

			// after the divider
			p_s11    <= dv_side.neg ? 64'd0 - dv_quo : dv_quo;
			side_s11 <= dv_side;

			ll_s12   <= {32'd0, q13l} * {32'd0, q13l};
			lh_s12   <= esc_pkg::mul_lo32(q13l, q13h);
			m8lo_s12 <= esc_pkg::mul_s_lo(p_s11[31:0], p8);
			m8hi_s12 <= esc_pkg::mul_lo32(p_s11[63:32], {{16{p8[15]}}, p8});
			p_s12    <= p_s11;
			side_s12 <= side_s11;

			qq_s13   <= ll_s12 + {lh_s12[30:0], 33'd0};
			w2b_s13  <= 64'($signed(h_m8) >>> 19);
			p_s13    <= p_s12;
			side_s13 <= side_s12;

			m9lo_s14 <= esc_pkg::mul_s_lo(qq_s13[31:0], p9);
			m9hi_s14 <= esc_pkg::mul_lo32(qq_s13[63:32], {{16{p9[15]}}, p9});
			p_s14    <= p_s13;
			w2b_s14  <= w2b_s13;
			side_s14 <= side_s13;

			sum_s15  <= p_s14 + 64'($signed(h_m9) >>> 25) + w2b_s14;
			side_s15 <= side_s14;

			res_s16.temperature_centideg <= side_s15.temp;
			res_s16.pressure_q24_8       <= side_s15.zero ? 32'd0 : pres_w[31:0];
			res_s16.humidity_q22_10      <= side_s15.hum;
		end
	end

	esc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (v_s10),
		.dvd       (ma_s10),
		.dvs       (mb_s10),
		.in_side   (side_s10),
		.out_valid (dv_valid),
		.quo       (dv_quo),
		.out_side  (dv_side)
	);

	assign result.valid = v_s16;
	assign result.data  = res_s16;

	`ESC_ASSERT_IMPL(a_stall_blocks_input, clk, arst_n, result.valid && !result.ready, !sample.ready)
	`ESC_ASSERT_IMPL(a_hum_range, clk, arst_n, result.valid, result.data.humidity_q22_10 <= 17'd102400)
	`ESC_ASSERT_NEXT(a_beat_enters, clk, arst_n, sample.valid && sample.ready, v_s1)
endmodule
